// ----- design/bta_pkg.sv -----
`timescale 1ns / 1ps
package bta_pkg;

    localparam int unsigned HEAP_BYTES      = 1048576;
    localparam int unsigned MIN_BLOCK_BYTES = 32;

    localparam int unsigned HEAP_LOG   = $clog2(HEAP_BYTES);
    localparam int unsigned MIN_LOG    = $clog2(MIN_BLOCK_BYTES);
    localparam int unsigned NODE_W     = HEAP_LOG - MIN_LOG + 1;
    localparam int unsigned NODE_COUNT = 2 ** NODE_W;
    localparam int unsigned LEVEL_W    = $clog2(HEAP_LOG - MIN_LOG + 1);
    localparam int unsigned OFF_W      = HEAP_LOG;
    localparam int unsigned BLK_W      = HEAP_LOG + 1;
    localparam int unsigned SLOG_W     = $clog2(HEAP_LOG + 1);
    localparam int unsigned SIZE_W     = 21;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned CMP_W      = (BLK_W > SIZE_W) ? BLK_W : SIZE_W;
    localparam int unsigned SDATA_W    = ((SIZE_W + ADDR_W + 7) / 8) * 8;
    localparam int unsigned MDATA_W    = ADDR_W;
    localparam int unsigned FLAG_W     = 2;

    typedef logic [FLAG_W-1:0] t_flags;

    localparam t_flags FLAG_NONE  = 2'b00;
    localparam t_flags FLAG_SPLIT = 2'b01;
    localparam t_flags FLAG_FREE  = 2'b10;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_TOO_BIG  = 2'd2,
        ST_BAD_FREE = 2'd3
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

endpackage

// ----- design/bta_flag_ram.sv -----
`timescale 1ns / 1ps
module bta_flag_ram #(
    parameter int unsigned ADDR_W = 16,
    parameter int unsigned DATA_W = 2
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/buddy_tree_allocator.sv -----
`timescale 1ns / 1ps
// Buddy allocator over a binary tree of node flags (split, free) in one RAM.
// Slave stream: tuser = op (0 alloc, 1 free); tdata = req_size[20:0],
//   block_addr[52:21]. Master stream: tuser = status, tdata = result_addr.
// Config channel writes heap_base; always ready, write only while idle.
// After reset a clearing pass writes all 65536 nodes free, with
//   s_axis_tready low; config writes are taken meanwhile.
// One transaction at a time, all node accesses through the single RAM port
//   pair, at most one read and one write per cycle:
//   alloc: a depth-first walk reads each node visited, splits a free
//     unsplit node larger than needed and backtracks where a node does
//     not fit, then reads sibling and parent at each level on the way
//     back to the root.
//   free: size rounding, lookup, then coalescing level by level.
// The result sits in an output register; the next request is accepted while
// it waits. A stalled receiver only holds the finished result; the block
// stops when the next result is done and the register is still full.
module buddy_tree_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bta_pkg::ADDR_W-1:0]  i_cfg_data,   // heap_base
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [bta_pkg::SDATA_W-1:0] i_s_axis_tdata, // req_size, block_addr
    input  logic                        i_s_axis_tuser, // op
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [bta_pkg::MDATA_W-1:0] o_m_axis_tdata, // result_addr
    output logic [1:0]                  o_m_axis_tuser  // status
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE,
        S_A_RD, S_A_EVAL, S_A_WL, S_A_WR, S_A_BT,
        S_U_UP, S_U_SIB, S_U_PAR,
        S_F_LOG, S_F_CHK, S_F_RD, S_F_EVAL, S_F_SIB, S_F_CO,
        S_DONE
    } t_state;

    t_state                        r_state, n_state;
    logic [bta_pkg::NODE_W-1:0]    r_node, n_node;
    logic [bta_pkg::LEVEL_W-1:0]   r_level, n_level;
    logic [bta_pkg::OFF_W-1:0]     r_off, n_off;
    logic [bta_pkg::SIZE_W-1:0]    r_size, n_size;
    logic [bta_pkg::ADDR_W-1:0]    r_raddr, n_raddr;
    logic [bta_pkg::SLOG_W-1:0]    r_slog, n_slog;
    logic                          r_cfree, n_cfree;
    logic                          r_sib_free, n_sib_free;
    bta_pkg::t_status              r_status, n_status;
    logic [bta_pkg::ADDR_W-1:0]    r_res, n_res;
    logic [bta_pkg::ADDR_W-1:0]    r_base;
    logic                          r_m_valid, n_m_valid;
    bta_pkg::t_status              r_m_status, n_m_status;
    logic [bta_pkg::ADDR_W-1:0]    r_m_addr, n_m_addr;

    logic                          ram_we;
    logic [bta_pkg::NODE_W-1:0]    ram_waddr;
    bta_pkg::t_flags               ram_wdata;
    logic [bta_pkg::NODE_W-1:0]    ram_raddr;
    bta_pkg::t_flags               ram_rdata;

    logic [bta_pkg::BLK_W-1:0]     blk;
    logic [bta_pkg::BLK_W-1:0]     half;
    logic [bta_pkg::NODE_W-1:0]    sibling;
    logic [bta_pkg::NODE_W-1:0]    parent;
    logic [bta_pkg::NODE_W-1:0]    left;
    logic [bta_pkg::SIZE_W-1:0]    in_req;
    logic [bta_pkg::ADDR_W-1:0]    in_addr;
    logic [bta_pkg::OFF_W-1:0]     align_mask;
    logic [bta_pkg::SLOG_W-1:0]    free_level;
    logic [bta_pkg::NODE_W-1:0]    lookup_node;
    logic                          clr_up;

    bta_flag_ram #(
        .ADDR_W (bta_pkg::NODE_W),
        .DATA_W (bta_pkg::FLAG_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_addr;
    assign o_m_axis_tuser  = r_m_status;

    assign in_req  = i_s_axis_tdata[bta_pkg::SIZE_W-1:0];
    assign in_addr = i_s_axis_tdata[bta_pkg::SIZE_W+bta_pkg::ADDR_W-1:bta_pkg::SIZE_W];

    assign blk     = bta_pkg::BLK_W'(bta_pkg::HEAP_BYTES) >> r_level;
    assign half    = blk >> 1;
    assign sibling = r_node[0] ? (r_node + 1'b1) : (r_node - 1'b1);
    assign parent  = (r_node - 1'b1) >> 1;
    assign left    = {r_node[bta_pkg::NODE_W-2:0], 1'b1};

    // slog == OFF_W wraps the shift to zero, giving an all-ones mask
    assign align_mask  = (bta_pkg::OFF_W'(1) << r_slog) - 1'b1;
    assign free_level  = bta_pkg::SLOG_W'(bta_pkg::HEAP_LOG) - r_slog;
    assign lookup_node = ((bta_pkg::NODE_W'(1) << free_level) - 1'b1)
                       + bta_pkg::NODE_W'(r_raddr[bta_pkg::OFF_W-1:0] >> r_slog);
    assign clr_up      = !r_cfree && !r_sib_free;

    always_comb begin
        n_state    = r_state;
        n_node     = r_node;
        n_level    = r_level;
        n_off      = r_off;
        n_size     = r_size;
        n_raddr    = r_raddr;
        n_slog     = r_slog;
        n_cfree    = r_cfree;
        n_sib_free = r_sib_free;
        n_status   = r_status;
        n_res      = r_res;
        n_m_valid  = r_m_valid;
        n_m_status = r_m_status;
        n_m_addr   = r_m_addr;
        ram_we     = 1'b0;
        ram_waddr  = r_node;
        ram_wdata  = bta_pkg::FLAG_FREE;
        ram_raddr  = r_node;

        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                ram_we = 1'b1;
                n_node = r_node + 1'b1;
                if (&r_node) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_res = '0;
                    if (bta_pkg::t_op'(i_s_axis_tuser) == bta_pkg::OP_ALLOC) begin
                        if (bta_pkg::CMP_W'(in_req) > bta_pkg::CMP_W'(bta_pkg::HEAP_BYTES)) begin
                            n_status = bta_pkg::ST_TOO_BIG;
                            n_state  = S_DONE;
                        end else begin
                            n_size  = (in_req < bta_pkg::SIZE_W'(bta_pkg::MIN_BLOCK_BYTES)) ?
                                      bta_pkg::SIZE_W'(bta_pkg::MIN_BLOCK_BYTES) : in_req;
                            n_node  = '0;
                            n_level = '0;
                            n_off   = '0;
                            n_state = S_A_RD;
                        end
                    end else begin
                        if (bta_pkg::CMP_W'(in_req) > bta_pkg::CMP_W'(bta_pkg::HEAP_BYTES)) begin
                            n_status = bta_pkg::ST_BAD_FREE;
                            n_state  = S_DONE;
                        end else begin
                            n_size  = in_req;
                            n_slog  = bta_pkg::SLOG_W'(bta_pkg::MIN_LOG);
                            n_raddr = in_addr - r_base;
                            n_state = S_F_LOG;
                        end
                    end
                end
            end
            S_A_RD: begin
                n_state = S_A_EVAL;
            end
            S_A_EVAL: begin
                if (!ram_rdata[1]) begin
                    n_state = S_A_BT;
                end else if (bta_pkg::CMP_W'(half) < bta_pkg::CMP_W'(r_size)) begin
                    if (ram_rdata[0]) begin
                        n_state = S_A_BT;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = bta_pkg::FLAG_NONE;
                        n_cfree   = 1'b0;
                        n_state   = S_U_UP;
                    end
                end else if (!ram_rdata[0]) begin
                    ram_we    = 1'b1;
                    ram_wdata = bta_pkg::FLAG_FREE | bta_pkg::FLAG_SPLIT;
                    n_state   = S_A_WL;
                end else begin
                    n_node  = left;
                    n_level = r_level + 1'b1;
                    n_state = S_A_RD;
                end
            end
            S_A_WL: begin
                ram_we    = 1'b1;
                ram_waddr = left;
                n_state   = S_A_WR;
            end
            S_A_WR: begin
                ram_we    = 1'b1;
                ram_waddr = left + 1'b1;
                n_node    = left;
                n_level   = r_level + 1'b1;
                n_state   = S_A_RD;
            end
            S_A_BT: begin
                if (r_node == '0) begin
                    n_status = bta_pkg::ST_NO_SPACE;
                    n_state  = S_DONE;
                end else if (r_node[0]) begin
                    n_node  = r_node + 1'b1;
                    n_off   = r_off + blk[bta_pkg::OFF_W-1:0];
                    n_state = S_A_RD;
                end else begin
                    n_node  = parent;
                    n_off   = r_off - blk[bta_pkg::OFF_W-1:0];
                    n_level = r_level - 1'b1;
                end
            end
            S_U_UP: begin
                ram_raddr = sibling;
                if (r_node == '0) begin
                    n_status = bta_pkg::ST_OK;
                    n_res    = r_base + bta_pkg::ADDR_W'(r_off);
                    n_state  = S_DONE;
                end else begin
                    n_state = S_U_SIB;
                end
            end
            S_U_SIB: begin
                ram_raddr  = parent;
                n_sib_free = ram_rdata[1];
                n_state    = S_U_PAR;
            end
            S_U_PAR: begin
                ram_waddr = parent;
                ram_wdata = ram_rdata & ~bta_pkg::FLAG_FREE;
                ram_we    = clr_up;
                n_cfree   = clr_up ? 1'b0 : ram_rdata[1];
                n_node    = parent;
                n_state   = S_U_UP;
            end
            S_F_LOG: begin
                if ((bta_pkg::CMP_W'(1) << r_slog) < bta_pkg::CMP_W'(r_size)) begin
                    n_slog = r_slog + 1'b1;
                end else begin
                    n_state = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (((r_raddr >> bta_pkg::HEAP_LOG) != '0)
                        || ((r_raddr[bta_pkg::OFF_W-1:0] & align_mask) != '0)) begin
                    n_status = bta_pkg::ST_BAD_FREE;
                    n_state  = S_DONE;
                end else begin
                    n_node  = lookup_node;
                    n_state = S_F_RD;
                end
            end
            S_F_RD: begin
                n_state = S_F_EVAL;
            end
            S_F_EVAL: begin
                if (ram_rdata[0]) begin
                    n_status = bta_pkg::ST_BAD_FREE;
                    n_state  = S_DONE;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | bta_pkg::FLAG_FREE;
                    n_state   = S_F_SIB;
                end
            end
            S_F_SIB: begin
                // the current node is always free and unsplit here
                ram_raddr = sibling;
                if (r_node == '0) begin
                    n_status = bta_pkg::ST_OK;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_F_CO;
                end
            end
            S_F_CO: begin
                if (ram_rdata == bta_pkg::FLAG_FREE) begin
                    ram_we    = 1'b1;
                    ram_waddr = parent;
                    n_node    = parent;
                    n_state   = S_F_SIB;
                end else begin
                    n_status = bta_pkg::ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_status;
                    n_m_addr   = r_res;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_node    <= '0;
            r_m_valid <= 1'b0;
            r_base    <= '0;
        end else begin
            r_state   <= n_state;
            r_node    <= n_node;
            r_m_valid <= n_m_valid;
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
        end
        r_level    <= n_level;
        r_off      <= n_off;
        r_size     <= n_size;
        r_raddr    <= n_raddr;
        r_slog     <= n_slog;
        r_cfree    <= n_cfree;
        r_sib_free <= n_sib_free;
        r_status   <= n_status;
        r_res      <= n_res;
        r_m_status <= n_m_status;
        r_m_addr   <= n_m_addr;
    end

endmodule

// ----- design/bta_checker.sv -----
`timescale 1ns / 1ps
module bta_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic                        i_s_axis_tuser,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [bta_pkg::MDATA_W-1:0] o_m_axis_tdata,
    input logic [1:0]                  o_m_axis_tuser
);

    logic       r_q0, r_q1;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign push = i_s_axis_tvalid && o_s_axis_tready;
    assign pop  = o_m_axis_tvalid && i_m_axis_tready;

    // ops of transactions accepted and not yet delivered, oldest in r_q0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push && pop) begin
            if (r_cnt == 2'd1) begin
                r_q0 <= i_s_axis_tuser;
            end else begin
                r_q0 <= r_q1;
                r_q1 <= i_s_axis_tuser;
            end
        end else if (push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= i_s_axis_tuser;
            end else begin
                r_q1 <= i_s_axis_tuser;
            end
        end else if (pop) begin
            r_q0 <= r_q1;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_cnt != 2'd0)
        else $error("result without a request");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != bta_pkg::ST_OK |-> o_m_axis_tdata == '0)
        else $error("nonzero address on error");

    a_free_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_cnt != 2'd0 && r_q0 == bta_pkg::OP_FREE |->
        o_m_axis_tdata == '0
        && (o_m_axis_tuser == bta_pkg::ST_OK || o_m_axis_tuser == bta_pkg::ST_BAD_FREE))
        else $error("bad status for free");

    a_alloc_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_cnt != 2'd0 && r_q0 == bta_pkg::OP_ALLOC |->
        o_m_axis_tuser != bta_pkg::ST_BAD_FREE)
        else $error("bad status for alloc");

endmodule

bind buddy_tree_allocator bta_checker u_bta_checker (.*);
